@@ hw/rtl/dbls_pkg.sv @@
// shared types and constants of the dual bus link supervisor
`timescale 1ns / 1ps

package dbls_pkg;

  // event codes carried in the input tuser
  typedef enum logic [2:0] {
    CMD_GOOD    = 3'd0,
    CMD_TIMEOUT = 3'd1,
    CMD_CRC     = 3'd2,
    CMD_PEER    = 3'd3,
    CMD_INIT    = 3'd4
  } cmd_t;

  // bus numbers that act
  localparam logic [1:0] BUS_ONE = 2'd1;
  localparam logic [1:0] BUS_TWO = 2'd2;

  // link mode codes
  localparam logic [1:0] LINK_NONE = 2'd0;
  localparam logic [1:0] LINK_BUS1 = 2'd1;
  localparam logic [1:0] LINK_BUS2 = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TWO = 1'b1;

  localparam int unsigned RUN_W     = 16;
  localparam int unsigned STAT_CNT_W = 32;
  localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;
  localparam logic [RUN_W-1:0] LIMIT_RESET = 16'd3;

  // per-bus status as seen after an update
  typedef struct packed {
    logic                  fault;
    logic                  many;
    logic                  tmo;
    logic [RUN_W-1:0]      run;
    logic [STAT_CNT_W-1:0] good;
    logic [STAT_CNT_W-1:0] ok;
    logic [STAT_CNT_W-1:0] fail;
  } bus_stat_t;

endpackage

@@ hw/rtl/dbls_bus_unit.sv @@
// per-bus fault flags, error run and packet counters
`timescale 1ns / 1ps

module dbls_bus_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  dbls_pkg::cmd_t                cmd_i,
  input  logic                          bad_i,
  input  logic [dbls_pkg::RUN_W-1:0]    limit_i,
  output logic                          fault_o,
  output logic                          trip_o,
  output dbls_pkg::bus_stat_t           stat_nxt_o
);
  import dbls_pkg::*;

  logic                   fault_r, fault_nxt;
  logic                   many_r, many_nxt;
  logic                   tmo_r, tmo_nxt;
  logic [RUN_W-1:0]       run_r, run_nxt;
  logic [COUNT_WIDTH-1:0] good_r, good_nxt;
  logic [COUNT_WIDTH-1:0] ok_r, ok_nxt;
  logic [COUNT_WIDTH-1:0] fail_r, fail_nxt;

  always_comb begin
    fault_nxt = fault_r;
    many_nxt  = many_r;
    tmo_nxt   = tmo_r;
    run_nxt   = run_r;
    good_nxt  = good_r;
    ok_nxt    = ok_r;
    fail_nxt  = fail_r;
    trip_o    = 1'b0;
    if (en_i) begin
      case (cmd_i)
        CMD_GOOD: begin
          good_nxt  = good_r + COUNT_WIDTH'(1);
          run_nxt   = '0;
          fault_nxt = 1'b0;
          many_nxt  = 1'b0;
          tmo_nxt   = 1'b0;
        end
        CMD_TIMEOUT: begin
          fault_nxt = 1'b1;
          tmo_nxt   = 1'b1;
        end
        CMD_CRC: begin
          // run saturates; a zero limit trips on the first error
          if (run_r != RUN_MAX) begin
            run_nxt = run_r + RUN_W'(1);
          end
          if (run_nxt >= limit_i) begin
            fault_nxt = 1'b1;
            many_nxt  = 1'b1;
            trip_o    = 1'b1;
          end
        end
        CMD_PEER: begin
          if (bad_i) begin
            fail_nxt = fail_r + COUNT_WIDTH'(1);
          end else begin
            ok_nxt = ok_r + COUNT_WIDTH'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= 1'b0;
      many_r  <= 1'b0;
      tmo_r   <= 1'b0;
      run_r   <= '0;
      good_r  <= '0;
      ok_r    <= '0;
      fail_r  <= '0;
    end else begin
      fault_r <= fault_nxt;
      many_r  <= many_nxt;
      tmo_r   <= tmo_nxt;
      run_r   <= run_nxt;
      good_r  <= good_nxt;
      ok_r    <= ok_nxt;
      fail_r  <= fail_nxt;
    end
  end

  assign fault_o          = fault_r;
  assign stat_nxt_o.fault = fault_nxt;
  assign stat_nxt_o.many  = many_nxt;
  assign stat_nxt_o.tmo   = tmo_nxt;
  assign stat_nxt_o.run   = run_nxt;
  assign stat_nxt_o.good  = STAT_CNT_W'(good_nxt);
  assign stat_nxt_o.ok    = STAT_CNT_W'(ok_nxt);
  assign stat_nxt_o.fail  = STAT_CNT_W'(fail_nxt);

endmodule

@@ hw/rtl/dual_bus_link_supervisor_unit.sv @@
// top level of the dual bus link supervisor
`timescale 1ns / 1ps

// Supervises a device reachable over two redundant buses. Every input transfer is one
// event (good packet, timeout, crc/framing error, peer service byte, init request) for
// bus 1 or 2, and yields exactly one result transfer carrying the link state after the
// event and the status of the named bus (zeros for bus numbers 0 and 3). One event is
// taken per clock cycle sustained while results are accepted; each event passes through the
// input register and the result register, with the whole state update done combinationally
// between them. Error limits are written through the cfg channel, which is always ready.
module dual_bus_link_supervisor_unit #(
  parameter int unsigned COUNT_WIDTH = 32  // width of the wrapping counters, 8 to 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // input events
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [0] peer_last_answer_bad, [1] peer_ready, rest zero
  input  logic [4:0]   in_tuser,   // [2:0] command, [4:3] bus
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [1:0] link_mode, [2] init_flag, [3] master_flag,
                                   // [4] fault_bus_one, [5] fault_bus_two,
                                   // [6] many_errors_flag, [7] timeout_flag,
                                   // [23:8] error_run, [55:24] good_packets,
                                   // [87:56] peer_good_count, [119:88] peer_bad_count,
                                   // [120] init_granted, rest zero
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [dbls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]  cfg_data
);
  import dbls_pkg::*;

  // error limits
  logic [RUN_W-1:0] limit_one_r, limit_two_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_one_r <= LIMIT_RESET;
      limit_two_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LIMIT_ONE: limit_one_r <= cfg_data;
        REG_LIMIT_TWO: limit_two_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register stage
  logic       s1_valid_r;
  cmd_t       s1_cmd_r;
  logic [1:0] s1_bus_r;
  logic       s1_bad_r;
  logic       s1_rdy_r;
  logic       out_free;
  logic       fire;

  assign out_free  = !out_tvalid || out_tready;
  assign fire      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= cmd_t'(in_tuser[2:0]);
      s1_bus_r <= in_tuser[4:3];
      s1_bad_r <= in_tdata[0];
      s1_rdy_r <= in_tdata[1];
    end
  end

  // per-bus units
  logic      sel_one, sel_two, bus_ok;
  logic      fault_one, fault_two, trip_one, trip_two;
  bus_stat_t stat_one, stat_two;

  assign sel_one = (s1_bus_r == BUS_ONE);
  assign sel_two = (s1_bus_r == BUS_TWO);
  assign bus_ok  = sel_one || sel_two;

  dbls_bus_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_bus_one (
    .clk        (clk),
    .rst_n      (rst_n),
    .en_i       (fire && sel_one),
    .cmd_i      (s1_cmd_r),
    .bad_i      (s1_bad_r),
    .limit_i    (limit_one_r),
    .fault_o    (fault_one),
    .trip_o     (trip_one),
    .stat_nxt_o (stat_one)
  );

  dbls_bus_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_bus_two (
    .clk        (clk),
    .rst_n      (rst_n),
    .en_i       (fire && sel_two),
    .cmd_i      (s1_cmd_r),
    .bad_i      (s1_bad_r),
    .limit_i    (limit_two_r),
    .fault_o    (fault_two),
    .trip_o     (trip_two),
    .stat_nxt_o (stat_two)
  );

  // link state
  logic       link_r, init_r, master_r, peer_rdy_r;
  logic [1:0] link_mode_r, link_mode_nxt;
  logic       init_nxt, master_nxt, peer_rdy_nxt, granted;
  logic       sel_fault, other_link;

  assign sel_fault  = sel_two ? fault_two : fault_one;
  // link already held on the other bus
  assign other_link = sel_two ? (link_mode_r == LINK_BUS1) : (link_mode_r == LINK_BUS2);

  always_comb begin
    link_mode_nxt = link_mode_r;
    init_nxt      = init_r;
    master_nxt    = master_r;
    peer_rdy_nxt  = peer_rdy_r;
    granted       = 1'b0;
    if (fire && bus_ok) begin
      case (s1_cmd_r)
        CMD_TIMEOUT: link_mode_nxt = LINK_NONE;
        CMD_CRC: begin
          if (trip_one || trip_two) begin
            link_mode_nxt = LINK_NONE;
          end
        end
        CMD_PEER: begin
          peer_rdy_nxt = s1_rdy_r;
          // peer not ready drops a link held on this bus
          if (!s1_rdy_r && link_mode_r == s1_bus_r) begin
            link_mode_nxt = LINK_NONE;
            init_nxt      = 1'b0;
          end
        end
        CMD_INIT: begin
          if (peer_rdy_r && !sel_fault && !other_link) begin
            init_nxt      = 1'b1;
            master_nxt    = sel_two;
            link_mode_nxt = s1_bus_r;
            granted       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_mode_r <= LINK_NONE;
      init_r      <= 1'b0;
      master_r    <= 1'b0;
      peer_rdy_r  <= 1'b0;
    end else begin
      link_mode_r <= link_mode_nxt;
      init_r      <= init_nxt;
      master_r    <= master_nxt;
      peer_rdy_r  <= peer_rdy_nxt;
    end
  end

  assign link_r = (link_mode_r != LINK_NONE);

  // result register
  logic       out_valid_r;
  logic [1:0] out_link_r;
  logic       out_init_r, out_master_r, out_f1_r, out_f2_r, out_granted_r;
  bus_stat_t  out_stat_r, sel_stat;

  always_comb begin
    if (sel_one) begin
      sel_stat = stat_one;
    end else if (sel_two) begin
      sel_stat = stat_two;
    end else begin
      sel_stat = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_link_r    <= link_mode_nxt;
      out_init_r    <= init_nxt;
      out_master_r  <= master_nxt;
      out_f1_r      <= stat_one.fault;
      out_f2_r      <= stat_two.fault;
      out_stat_r    <= sel_stat;
      out_granted_r <= granted;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_granted_r, out_stat_r.fail, out_stat_r.ok,
                       out_stat_r.good, out_stat_r.run, out_stat_r.tmo, out_stat_r.many,
                       out_f2_r, out_f1_r, out_master_r, out_init_r, out_link_r};

  // link on bus 2 always means master, on bus 1 never
  a_master_bus2 : assert property (@(posedge clk) disable iff (!rst_n)
    (link_mode_r == LINK_BUS2) |-> master_r)
    else $error("link on bus 2 without master flag");

  a_master_bus1 : assert property (@(posedge clk) disable iff (!rst_n)
    (link_mode_r == LINK_BUS1) |-> !master_r)
    else $error("link on bus 1 with master flag");

  // a held link never sits on a faulted bus
  a_link_fault : assert property (@(posedge clk) disable iff (!rst_n)
    link_r |-> !((link_mode_r == LINK_BUS1 && fault_one) ||
                 (link_mode_r == LINK_BUS2 && fault_two)))
    else $error("link held on a faulted bus");

  // a granted init reports an initialized link
  a_grant : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r) |-> (out_init_r && out_link_r != LINK_NONE))
    else $error("init granted without initialized link");

endmodule
